>>> design/jht_pkg.sv
// ----------------------------------------------------------------------------
// Joint hierarchy transform package
// Shared constants, codes, the multiply-accumulate control type and the
// 32-bit saturation helper.
// ----------------------------------------------------------------------------
package jht_pkg;

	localparam int MAX_JOINTS_DEF = 64;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int IN_DATA_W  = 144;
	localparam int OUT_DATA_W = 136;

	typedef enum logic [1:0] {
		REQ_BIND_ROW = 2'd0,
		REQ_ROTATION = 2'd1,
		REQ_POSITION = 2'd2,
		REQ_COMPUTE  = 2'd3
	} req_type_t;

	localparam logic KIND_WORLD = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic [3:0] tag;
	} mac_op_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

>>> design/jht_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/jht_mac.sv
// ----------------------------------------------------------------------------
// Joint hierarchy transform multiply-accumulate unit
// Pipelined signed 32x32 multiply, fixed-point truncation toward zero and
// accumulation of a run of products marked by first and last flags.
// ----------------------------------------------------------------------------
module jht_mac #(
	parameter int FRAC_BITS = jht_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  jht_pkg::mac_op_t            op,
	input  logic signed [31:0]          a,
	input  logic signed [31:0]          b,
	output logic                        res_valid,
	output logic [3:0]                  res_tag,
	output logic signed [65-FRAC_BITS:0] res
);
	import jht_pkg::*;

	localparam int TRUNC_W = 64 - FRAC_BITS;
	localparam int ACC_W   = TRUNC_W + 2;

	mac_op_t                    op_s1;
	mac_op_t                    op_s2;
	logic signed [63:0]         prod_s1;
	logic signed [TRUNC_W-1:0]  trunc_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       res_valid_q;
	logic [3:0]                 res_tag_q;
	logic signed [63:0]         shifted;
	logic                       round_up;
	logic signed [TRUNC_W-1:0]  trunc_next;
	logic signed [ACC_W-1:0]    acc_next;

	always_comb begin
		shifted    = prod_s1 >>> FRAC_BITS;
		round_up   = prod_s1[63] && (prod_s1[FRAC_BITS-1:0] != '0);
		trunc_next = TRUNC_W'(shifted + 64'(round_up));
		acc_next   = op_s2.first ? ACC_W'(trunc_s2) : acc_q + ACC_W'(trunc_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= '0;
			op_s2       <= '0;
			res_valid_q <= 1'b0;
			res_tag_q   <= '0;
		end else begin
			op_s1       <= op;
			op_s2       <= op_s1;
			res_valid_q <= op_s2.valid && op_s2.last;
			res_tag_q   <= op_s2.tag;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= a * b;
		trunc_s2 <= trunc_next;
		if (op_s2.valid) begin
			acc_q <= acc_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_tag   = res_tag_q;
	assign res       = acc_q;

endmodule

>>> design/joint_hierarchy_transform.sv
// ----------------------------------------------------------------------------
// Joint hierarchy transform
// Skinning matrix palette: local T*R*S, world and final matrices per joint.
// ----------------------------------------------------------------------------
// The input stream carries one item per beat: bind row loads, rotation and
// position staging, and scale items that start a compute. tuser holds the
// item kind. The output stream gives four world rows and then four final
// rows per compute; tuser marks the matrix kind and tlast the eighth row.
// The register joint_count is written through cfg_we and cfg_wdata.
// A compute is paced by the single multiply-accumulate unit: 9 quaternion
// products, 9 scale products, 64 parent products (skipped for joint zero),
// a world write-back of 16 words and 64 bind products, each phase draining
// the multiply-accumulate pipeline, then eight output beats. One item is
// worked on at a time.
// Reset clears the control state and sets joint_count to one; the matrix
// memories hold nothing valid until written.
// When the receiver stalls, the block holds the pending row and waits; the
// input side stays closed until the eighth row has entered the output
// register, and reopens while that row waits to be taken.
// ----------------------------------------------------------------------------
module joint_hierarchy_transform #(
	parameter int MAX_JOINTS = jht_pkg::MAX_JOINTS_DEF,
	parameter int FRAC_BITS  = jht_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// joint, parent, row, e0, e1, e2, e3, zero fill
	input  logic [jht_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic [1:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_joint, out_row, c0, c1, c2, c3
	output logic [jht_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// matrix_kind
	output logic [0:0]                       m_axis_tuser,
	output logic                             m_axis_tlast,
	input  logic                             cfg_we,
	input  logic [6:0]                       cfg_wdata
);
	import jht_pkg::*;

	localparam int DEPTH = MAX_JOINTS * 16;
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = 64 - FRAC_BITS;
	localparam int ACC_W = 66 - FRAC_BITS;
	localparam int RW    = QW + 3;
	localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_QUAT, ST_ROT, ST_SCALE,
		ST_WORLD, ST_STORE, ST_FINAL, ST_EMIT
	} state_t;

	function automatic logic [3:0] local_idx(input logic [3:0] t);
		logic [3:0] v;
		unique case (t)
			4'd0: v = 4'd0;
			4'd1: v = 4'd1;
			4'd2: v = 4'd2;
			4'd3: v = 4'd4;
			4'd4: v = 4'd5;
			4'd5: v = 4'd6;
			4'd6: v = 4'd8;
			4'd7: v = 4'd9;
			4'd8: v = 4'd10;
			default: v = 4'd0;
		endcase
		return v;
	endfunction

	state_t                    state_q;
	logic [6:0]                cnt_q;
	logic [4:0]                res_cnt_q;
	logic [6:0]                joint_count_q;
	logic [5:0]                joint_q;
	logic [5:0]                parent_q;
	logic [1:0]                row_q;
	logic signed [31:0]        e_q [4];
	logic signed [31:0]        qx_q, qy_q, qz_q, qw_q;
	logic signed [31:0]        pos_q [3];
	logic signed [QW-1:0]      qp_q [9];
	logic signed [31:0]        r_q [9];
	logic signed [31:0]        local_q [12];
	logic signed [31:0]        world_q [16];
	logic signed [31:0]        fin_q [16];

	logic                      m_valid_q;
	logic [5:0]                m_joint_q;
	logic                      m_kind_q;
	logic [1:0]                m_row_q;
	logic signed [31:0]        m_c_q [4];
	logic                      m_last_q;

	logic [5:0]                in_joint, in_parent;
	logic [1:0]                in_row;
	logic signed [31:0]        in_e [4];
	req_type_t                 in_type;
	logic                      accept;
	logic                      in_joint_ok;

	logic                      running;
	logic [6:0]                op_count;
	logic                      issue;
	mac_op_t                   op_s0;
	mac_op_t                   op_s1;
	logic [5:0]                idx_s1;
	logic signed [31:0]        mac_a, mac_b;
	logic                      mac_res_valid;
	logic [3:0]                mac_res_tag;
	logic signed [ACC_W-1:0]   mac_res;
	logic signed [31:0]        res_sat;
	logic                      phase_done;
	logic                      parent_ok;

	logic [1:0]                e_idx;
	logic [3:0]                scale_pos;
	logic [1:0]                scale_col;
	logic [3:0]                w_idx;
	logic signed [31:0]        w_val;

	logic                      bind_we, world_we;
	logic [AW-1:0]             bind_waddr, bind_raddr, world_waddr, world_raddr;
	logic [31:0]               bind_rdata, world_rdata;

	logic signed [RW-1:0]      xx, yy, zz, xy, xz, yz, wx, wy, wz, one_r;

	assign in_joint  = s_axis_tdata[5:0];
	assign in_parent = s_axis_tdata[11:6];
	assign in_row    = s_axis_tdata[13:12];
	assign in_e[0]   = s_axis_tdata[45:14];
	assign in_e[1]   = s_axis_tdata[77:46];
	assign in_e[2]   = s_axis_tdata[109:78];
	assign in_e[3]   = s_axis_tdata[141:110];
	assign in_type   = req_type_t'(s_axis_tuser);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_joint_ok   = 32'(in_joint) < MAX_JOINTS;
	assign parent_ok     = 32'(parent_q) < MAX_JOINTS;

	always_comb begin
		running  = 1'b0;
		op_count = 7'd0;
		unique case (state_q)
			ST_QUAT:  begin running = 1'b1; op_count = 7'd9;  end
			ST_SCALE: begin running = 1'b1; op_count = 7'd9;  end
			ST_WORLD: begin running = 1'b1; op_count = 7'd64; end
			ST_FINAL: begin running = 1'b1; op_count = 7'd64; end
			default:  begin running = 1'b0; op_count = 7'd0;  end
		endcase
		issue      = running && (cnt_q < op_count);
		phase_done = running && (7'(res_cnt_q) == (op_count > 7'd16 ? 7'd16 : op_count));
		op_s0.valid = issue;
		if (state_q == ST_WORLD || state_q == ST_FINAL) begin
			op_s0.first = (cnt_q[1:0] == 2'd0);
			op_s0.last  = (cnt_q[1:0] == 2'd3);
			op_s0.tag   = cnt_q[5:2];
		end else begin
			op_s0.first = 1'b1;
			op_s0.last  = 1'b1;
			op_s0.tag   = cnt_q[3:0];
		end
	end

	// Issue stage: addresses go to the memories now, operands form next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= '0;
			idx_s1 <= '0;
		end else begin
			op_s1  <= op_s0;
			idx_s1 <= cnt_q[5:0];
		end
	end

	assign world_raddr = AW'((32'(parent_q) << 4) | 32'({cnt_q[5:4], cnt_q[1:0]}));
	assign bind_raddr  = AW'((32'(joint_q) << 4) | 32'({cnt_q[1:0], cnt_q[3:2]}));
	assign bind_we     = (state_q == ST_LOAD);
	assign bind_waddr  = AW'((32'(joint_q) << 4) | 32'({row_q, cnt_q[1:0]}));
	assign world_we    = (state_q == ST_STORE);
	assign world_waddr = AW'((32'(joint_q) << 4) | 32'(cnt_q[3:0]));

	assign scale_pos = local_idx(idx_s1[3:0]);
	assign scale_col = scale_pos[1:0];
	assign e_idx     = (state_q == ST_LOAD) ? cnt_q[1:0] : scale_col;
	assign w_idx     = (state_q == ST_STORE) ? cnt_q[3:0] : {idx_s1[5:4], idx_s1[1:0]};
	assign w_val     = world_q[w_idx];

	always_comb begin
		mac_a = '0;
		mac_b = '0;
		unique case (state_q)
			ST_QUAT: begin
				unique case (idx_s1[3:0])
					4'd0: begin mac_a = qx_q; mac_b = qx_q; end
					4'd1: begin mac_a = qy_q; mac_b = qy_q; end
					4'd2: begin mac_a = qz_q; mac_b = qz_q; end
					4'd3: begin mac_a = qx_q; mac_b = qy_q; end
					4'd4: begin mac_a = qx_q; mac_b = qz_q; end
					4'd5: begin mac_a = qy_q; mac_b = qz_q; end
					4'd6: begin mac_a = qw_q; mac_b = qx_q; end
					4'd7: begin mac_a = qw_q; mac_b = qy_q; end
					4'd8: begin mac_a = qw_q; mac_b = qz_q; end
					default: begin mac_a = qx_q; mac_b = qx_q; end
				endcase
			end
			ST_SCALE: begin
				mac_a = r_q[idx_s1[3:0]];
				mac_b = e_q[e_idx];
			end
			ST_WORLD: begin
				if (parent_ok) begin
					mac_a = world_rdata;
				end else begin
					mac_a = (idx_s1[5:4] == idx_s1[1:0]) ? ONE : 32'sd0;
				end
				if (idx_s1[1:0] == 2'd3) begin
					mac_b = (idx_s1[3:2] == 2'd3) ? ONE : 32'sd0;
				end else begin
					mac_b = local_q[{idx_s1[1:0], idx_s1[3:2]}];
				end
			end
			ST_FINAL: begin
				mac_a = w_val;
				mac_b = bind_rdata;
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase
	end

	jht_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_bind_ram (
		.clk   (clk),
		.we    (bind_we),
		.waddr (bind_waddr),
		.wdata (e_q[e_idx]),
		.raddr (bind_raddr),
		.rdata (bind_rdata)
	);

	jht_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_world_ram (
		.clk   (clk),
		.we    (world_we),
		.waddr (world_waddr),
		.wdata (w_val),
		.raddr (world_raddr),
		.rdata (world_rdata)
	);

	jht_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_s1),
		.a         (mac_a),
		.b         (mac_b),
		.res_valid (mac_res_valid),
		.res_tag   (mac_res_tag),
		.res       (mac_res)
	);

	assign res_sat = sat32(64'(mac_res));

	always_comb begin
		xx    = RW'(qp_q[0]);
		yy    = RW'(qp_q[1]);
		zz    = RW'(qp_q[2]);
		xy    = RW'(qp_q[3]);
		xz    = RW'(qp_q[4]);
		yz    = RW'(qp_q[5]);
		wx    = RW'(qp_q[6]);
		wy    = RW'(qp_q[7]);
		wz    = RW'(qp_q[8]);
		one_r = RW'(ONE);
	end

	// Datapath storage written by phase.
	always_ff @(posedge clk) begin
		if (accept) begin
			joint_q  <= in_joint;
			parent_q <= in_parent;
			row_q    <= in_row;
			for (int c = 0; c < 4; c++) begin
				e_q[c] <= in_e[c];
			end
			if (in_type == REQ_ROTATION && in_joint_ok) begin
				qx_q <= in_e[0];
				qy_q <= in_e[1];
				qz_q <= in_e[2];
				qw_q <= in_e[3];
			end
			if (in_type == REQ_POSITION && in_joint_ok) begin
				for (int c = 0; c < 3; c++) begin
					pos_q[c] <= in_e[c];
				end
			end
		end
		if (mac_res_valid) begin
			unique case (state_q)
				ST_QUAT:  qp_q[mac_res_tag] <= QW'(mac_res);
				ST_SCALE: local_q[local_idx(mac_res_tag)] <= res_sat;
				ST_WORLD: world_q[mac_res_tag] <= res_sat;
				ST_FINAL: fin_q[mac_res_tag] <= res_sat;
				default:  ;
			endcase
		end
		if (state_q == ST_ROT) begin
			r_q[0] <= sat32(64'(one_r - ((yy + zz) <<< 1)));
			r_q[1] <= sat32(64'((xy - wz) <<< 1));
			r_q[2] <= sat32(64'((xz + wy) <<< 1));
			r_q[3] <= sat32(64'((xy + wz) <<< 1));
			r_q[4] <= sat32(64'(one_r - ((xx + zz) <<< 1)));
			r_q[5] <= sat32(64'((yz - wx) <<< 1));
			r_q[6] <= sat32(64'((xz - wy) <<< 1));
			r_q[7] <= sat32(64'((yz + wx) <<< 1));
			r_q[8] <= sat32(64'(one_r - ((xx + yy) <<< 1)));
			local_q[3]  <= pos_q[0];
			local_q[7]  <= pos_q[1];
			local_q[11] <= pos_q[2];
		end
		if (state_q == ST_SCALE && phase_done && joint_q == 6'd0) begin
			for (int i = 0; i < 12; i++) begin
				world_q[i] <= local_q[i];
			end
			world_q[12] <= 32'sd0;
			world_q[13] <= 32'sd0;
			world_q[14] <= 32'sd0;
			world_q[15] <= ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			res_cnt_q     <= '0;
			joint_count_q <= 7'd1;
			m_valid_q     <= 1'b0;
			m_joint_q     <= '0;
			m_kind_q      <= KIND_WORLD;
			m_row_q       <= '0;
			m_last_q      <= 1'b0;
			for (int c = 0; c < 4; c++) begin
				m_c_q[c] <= '0;
			end
		end else begin
			if (cfg_we) begin
				joint_count_q <= cfg_wdata;
			end
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (issue) begin
				cnt_q <= cnt_q + 7'd1;
			end
			if (mac_res_valid) begin
				res_cnt_q <= res_cnt_q + 5'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q     <= '0;
					res_cnt_q <= '0;
					if (accept && in_joint_ok) begin
						unique case (in_type)
							REQ_BIND_ROW: state_q <= ST_LOAD;
							REQ_COMPUTE: begin
								if ({1'b0, in_joint} < joint_count_q) begin
									state_q <= ST_QUAT;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[1:0] == 2'd3) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QUAT: begin
					if (phase_done) begin
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					cnt_q     <= '0;
					res_cnt_q <= '0;
					state_q   <= ST_SCALE;
				end
				ST_SCALE: begin
					if (phase_done) begin
						cnt_q     <= '0;
						res_cnt_q <= '0;
						state_q   <= (joint_q == 6'd0) ? ST_STORE : ST_WORLD;
					end
				end
				ST_WORLD: begin
					if (phase_done) begin
						cnt_q     <= '0;
						res_cnt_q <= '0;
						state_q   <= ST_STORE;
					end
				end
				ST_STORE: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[3:0] == 4'd15) begin
						cnt_q     <= '0;
						res_cnt_q <= '0;
						state_q   <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (phase_done) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_joint_q <= joint_q;
						m_kind_q  <= cnt_q[2] ? KIND_FINAL : KIND_WORLD;
						m_row_q   <= cnt_q[1:0];
						m_last_q  <= (cnt_q[2:0] == 3'd7);
						for (int c = 0; c < 4; c++) begin
							m_c_q[c] <= cnt_q[2] ? fin_q[{cnt_q[1:0], 2'(c)}]
							                     : world_q[{cnt_q[1:0], 2'(c)}];
						end
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q[2:0] == 3'd7) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = {m_c_q[3], m_c_q[2], m_c_q[1], m_c_q[0], m_row_q, m_joint_q};
	assign m_axis_tuser[0] = m_kind_q;
	assign m_axis_tlast    = m_last_q;

`ifndef NO_ASSERTIONS
	a_last_is_final_row3: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] == KIND_FINAL && m_axis_tdata[7:6] == 2'd3)
		else $error("last beat is not final row three");

	a_result_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mac_res_valid |-> state_q == ST_QUAT || state_q == ST_SCALE ||
			state_q == ST_WORLD || state_q == ST_FINAL)
		else $error("product result arrived outside a compute phase");

	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !mac_res_valid && !op_s1.valid)
		else $error("pipeline not drained while emitting");
`endif

endmodule
